>>> rtl/hrl_pkg.sv
// Shared types, constants and register codes for the hue-rotating lamp color unit.
package hrl_pkg;

  localparam int LAMPS_DEF      = 16;
  localparam int COLOR_BITS_DEF = 12;
  localparam int HUE_W          = 16;
  localparam int LAMP_IDX_W     = 4;
  localparam int Q12_W          = 13;
  localparam int LC_W           = 5;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [Q12_W-1:0] Q12_ONE = 13'd4096;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd3;

  // Register reset values
  localparam logic [LC_W-1:0]  RST_LAMP_COUNT = 5'd16;
  localparam logic [HUE_W-1:0] RST_HUE_STEP   = 16'd0;
  localparam logic [Q12_W-1:0] RST_SATURATION = 13'd4096;
  localparam logic [Q12_W-1:0] RST_BRIGHTNESS = 13'd3072;

  // Item kinds; the fourth code is dropped at the front
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_TICK    = 2'd1,
    OP_REFRESH = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    op_t              op;
    logic [HUE_W-1:0] start;
    logic [HUE_W-1:0] spacing;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Configuration as seen by the back end, Q12 values already clamped
  typedef struct packed {
    logic [LC_W-1:0]  lamp_count;
    logic [HUE_W-1:0] hue_step;
    logic [Q12_W-1:0] saturation;
    logic [Q12_W-1:0] brightness;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [HUE_W-1:0]      hue;
    logic [LAMP_IDX_W-1:0] lamp_index;
    logic                  last;
  } issue_t;

endpackage

>>> rtl/hrl_ifs.sv
// Channel interfaces: input items, result items and configuration writes.
interface hrl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] hue_start;
  logic [15:0] hue_spacing;
  modport source(output valid, kind, hue_start, hue_spacing, input ready);
  modport sink(input valid, kind, hue_start, hue_spacing, output ready);
endinterface

interface hrl_out_if #(parameter int COLOR_BITS = hrl_pkg::COLOR_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic [3:0]            lamp_index;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;
  logic                  last;
  modport source(output valid, lamp_index, red, green, blue, last, input ready);
  modport sink(input valid, lamp_index, red, green, blue, last, output ready);
endinterface

interface hrl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hrl_pkg::CFG_IDX_W-1:0]   index;
  logic [hrl_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/hrl_front.sv
// Front end: accepts items, drops the unused kind and queues commands for the back end.
module hrl_front (
  input  logic             clk,
  input  logic             rst_n,
  hrl_in_if.sink           in_ch,
  input  logic             pop,
  output hrl_pkg::q_head_t head
);
  import hrl_pkg::*;

  localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  cmd_t             in_cmd;

  // Take an item whenever the queue has room
  assign in_ch.ready = (count_r != CNT_W'(QUEUE_DEPTH));

  // Queue only kinds that do something
  assign push = in_ch.valid && in_ch.ready &&
                (in_ch.kind inside {OP_SET, OP_TICK, OP_REFRESH});

  assign in_cmd.op      = op_t'(in_ch.kind);
  assign in_cmd.start   = in_ch.hue_start;
  assign in_cmd.spacing = in_ch.hue_spacing;

  assign head.valid = (count_r != '0);
  assign head.cmd   = q_mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? QA_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QA_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = CNT_W'(count_r + 1'b1);
      2'b01:   count_nxt = CNT_W'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the command on transfer
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

>>> rtl/hrl_seq.sv
// Back-end sequencer: keeps the hue ramp and walks the lamps in use for each emit command.
module hrl_seq #(
  parameter int LAMPS = hrl_pkg::LAMPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hrl_pkg::cfg_t    cfg,
  input  hrl_pkg::q_head_t head,
  output logic             pop,
  input  logic             adv,
  output hrl_pkg::issue_t  issue
);
  import hrl_pkg::*;

  localparam int IDX_W = (LAMPS > 1) ? $clog2(LAMPS) : 1;

  // Every stored hue is base + i * spacing: set writes both, tick moves the base
  seq_state_t       state_r, state_nxt;
  logic [HUE_W-1:0] base_r, base_nxt;
  logic [HUE_W-1:0] space_r, space_nxt;
  logic [HUE_W-1:0] hue_r, hue_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] last_idx;
  logic             at_last;

  // Clamp the lamp count into 1..LAMPS and take the last index
  always_comb begin
    if (cfg.lamp_count == '0) begin
      last_idx = '0;
    end else if (int'(cfg.lamp_count) > LAMPS) begin
      last_idx = IDX_W'(LAMPS - 1);
    end else begin
      last_idx = IDX_W'(cfg.lamp_count - 1'b1);
    end
  end

  assign at_last = (idx_r == last_idx);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid && (head.cmd.op inside {OP_TICK, OP_REFRESH})) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (adv && at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop              = 1'b0;
    issue.valid      = 1'b0;
    issue.hue        = hue_r;
    issue.lamp_index = LAMP_IDX_W'(idx_r);
    issue.last       = at_last;
    case (state_r)
      ST_IDLE: pop         = head.valid;
      ST_EMIT: issue.valid = 1'b1;
      default: ;
    endcase
  end

  // Hue ramp and lamp counter
  always_comb begin
    base_nxt  = base_r;
    space_nxt = space_r;
    hue_nxt   = hue_r;
    idx_nxt   = idx_r;
    if (state_r == ST_IDLE && head.valid) begin
      case (head.cmd.op)
        OP_SET: begin
          base_nxt  = head.cmd.start;
          space_nxt = head.cmd.spacing;
        end
        OP_TICK: begin
          base_nxt = HUE_W'(base_r + cfg.hue_step);
          hue_nxt  = HUE_W'(base_r + cfg.hue_step);
          idx_nxt  = '0;
        end
        OP_REFRESH: begin
          hue_nxt = base_r;
          idx_nxt = '0;
        end
        default: ;
      endcase
    end else if (state_r == ST_EMIT && adv) begin
      hue_nxt = HUE_W'(hue_r + space_r);
      idx_nxt = IDX_W'(idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      base_r  <= '0;
      space_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      space_r <= space_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hue_r <= hue_nxt;
  end

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && adv && at_last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept walking after the last lamp");

  a_set_loads_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && head.valid && head.cmd.op == OP_SET)
      |=> (base_r == $past(head.cmd.start) && state_r == ST_IDLE))
    else $error("set command did not load the hue base");

  a_tick_starts_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && head.valid && head.cmd.op == OP_TICK)
      |=> (hue_r == base_r && idx_r == '0))
    else $error("tick walk does not start at the advanced base");

  a_stall_holds_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !adv) |=> ($stable(idx_r) && $stable(hue_r)))
    else $error("lamp walk moved while the color pipeline stalled");

endmodule

>>> rtl/hrl_color.sv
// Three-stage HSV to RGB pipeline ending in the result register.
module hrl_color #(
  parameter int COLOR_BITS = hrl_pkg::COLOR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hrl_pkg::cfg_t   cfg,
  input  hrl_pkg::issue_t issue,
  output logic            adv,
  hrl_out_if.source       out_ch
);
  import hrl_pkg::*;

  localparam logic [COLOR_BITS-1:0] COLOR_MAX = {COLOR_BITS{1'b1}};
  localparam int SCL_W = Q12_W + COLOR_BITS;

  // Stage 1: sector and fraction products
  logic [18:0]       x6;
  logic [15:0]       frac;
  logic [16:0]       frac_inv;
  logic [28:0]       fs_prod;
  logic [29:0]       gs_prod;
  logic              s1_v_r;
  logic [2:0]        s1_sector_r;
  logic [Q12_W-1:0]  s1_fs_r;
  logic [Q12_W-1:0]  s1_gs_r;
  logic [LAMP_IDX_W-1:0] s1_idx_r;
  logic              s1_last_r;

  // Stage 2: p, q, t levels
  logic [25:0]       p_prod, q_prod, t_prod;
  logic              s2_v_r;
  logic [2:0]        s2_sector_r;
  logic [Q12_W-1:0]  s2_p_r, s2_q_r, s2_t_r;
  logic [LAMP_IDX_W-1:0] s2_idx_r;
  logic              s2_last_r;

  // Stage 3: channel select and output scaling
  logic [Q12_W-1:0]  cr, cg, cb;
  logic [SCL_W-1:0]  r_prod, g_prod, b_prod;
  logic              s3_v_r;
  logic [COLOR_BITS-1:0] s3_r_r, s3_g_r, s3_b_r;
  logic [LAMP_IDX_W-1:0] s3_idx_r;
  logic              s3_last_r;

  // Move the whole pipe whenever the result register is free or being taken
  assign adv = !s3_v_r || out_ch.ready;

  assign x6       = (19'(issue.hue) << 2) + (19'(issue.hue) << 1);
  assign frac     = x6[15:0];
  assign frac_inv = 17'h10000 - 17'(frac);
  assign fs_prod  = 29'(frac) * 29'(cfg.saturation);
  assign gs_prod  = 30'(frac_inv) * 30'(cfg.saturation);

  assign p_prod = 26'(cfg.brightness) * 26'(Q12_W'(Q12_ONE - cfg.saturation));
  assign q_prod = 26'(cfg.brightness) * 26'(Q12_W'(Q12_ONE - s1_fs_r));
  assign t_prod = 26'(cfg.brightness) * 26'(Q12_W'(Q12_ONE - s1_gs_r));

  // Pick channels by sector
  always_comb begin
    case (s2_sector_r)
      3'd0:    begin cr = cfg.brightness; cg = s2_t_r;         cb = s2_p_r;         end
      3'd1:    begin cr = s2_q_r;         cg = cfg.brightness; cb = s2_p_r;         end
      3'd2:    begin cr = s2_p_r;         cg = cfg.brightness; cb = s2_t_r;         end
      3'd3:    begin cr = s2_p_r;         cg = s2_q_r;         cb = cfg.brightness; end
      3'd4:    begin cr = s2_t_r;         cg = s2_p_r;         cb = cfg.brightness; end
      default: begin cr = cfg.brightness; cg = s2_p_r;         cb = s2_q_r;         end
    endcase
  end

  assign r_prod = SCL_W'(cr) * SCL_W'(COLOR_MAX);
  assign g_prod = SCL_W'(cg) * SCL_W'(COLOR_MAX);
  assign b_prod = SCL_W'(cb) * SCL_W'(COLOR_MAX);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= issue.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sector_r <= x6[18:16];
      s1_fs_r     <= Q12_W'(fs_prod >> 16);
      s1_gs_r     <= Q12_W'(gs_prod >> 16);
      s1_idx_r    <= issue.lamp_index;
      s1_last_r   <= issue.last;

      s2_sector_r <= s1_sector_r;
      s2_p_r      <= Q12_W'(p_prod >> 12);
      s2_q_r      <= Q12_W'(q_prod >> 12);
      s2_t_r      <= Q12_W'(t_prod >> 12);
      s2_idx_r    <= s1_idx_r;
      s2_last_r   <= s1_last_r;

      s3_r_r      <= COLOR_BITS'(r_prod >> 12);
      s3_g_r      <= COLOR_BITS'(g_prod >> 12);
      s3_b_r      <= COLOR_BITS'(b_prod >> 12);
      s3_idx_r    <= s2_idx_r;
      s3_last_r   <= s2_last_r;
    end
  end

  assign out_ch.valid      = s3_v_r;
  assign out_ch.lamp_index = s3_idx_r;
  assign out_ch.red        = s3_r_r;
  assign out_ch.green      = s3_g_r;
  assign out_ch.blue       = s3_b_r;
  assign out_ch.last       = s3_last_r;

endmodule

>>> rtl/hue_rotating_hsv_to_rgb_lamps_unit.sv
// Top level: configuration registers, command queue, lamp sequencer and color pipeline.
// Keeps a hue per lamp and turns it into RGB drive levels. A set-hues item is handled in
// the sequencer's idle state and gives no results; a tick or refresh item occupies the
// sequencer while it walks the lamps in use, and its colors pass through the three-stage
// conversion pipeline and leave it one color per cycle while the output is taken. The
// lamp walk in the sequencer sets the rate. A two-entry command queue in front takes new
// items while a walk is under way; an item of the unused kind is taken and dropped.
// Reset leaves all hues at zero with no clearing pass. Configuration writes are taken
// every cycle and belong in idle time.
module hue_rotating_hsv_to_rgb_lamps_unit #(
  parameter int LAMPS      = hrl_pkg::LAMPS_DEF,
  parameter int COLOR_BITS = hrl_pkg::COLOR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hrl_in_if.sink    in_ch,
  hrl_out_if.source out_ch,
  hrl_cfg_if.sink   cfg_ch
);
  import hrl_pkg::*;

  logic [LC_W-1:0]  lamp_count_r, lamp_count_nxt;
  logic [HUE_W-1:0] hue_step_r, hue_step_nxt;
  logic [Q12_W-1:0] saturation_r, saturation_nxt;
  logic [Q12_W-1:0] brightness_r, brightness_nxt;
  cfg_t             cfg;
  q_head_t          head;
  logic             pop;
  logic             adv;
  issue_t           issue;

  assign cfg_ch.ready = 1'b1;

  // Decode register writes
  always_comb begin
    lamp_count_nxt = lamp_count_r;
    hue_step_nxt   = hue_step_r;
    saturation_nxt = saturation_r;
    brightness_nxt = brightness_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LAMP_COUNT: lamp_count_nxt = cfg_ch.data[LC_W-1:0];
        CFG_HUE_STEP:   hue_step_nxt   = cfg_ch.data[HUE_W-1:0];
        CFG_SATURATION: saturation_nxt = cfg_ch.data[Q12_W-1:0];
        CFG_BRIGHTNESS: brightness_nxt = cfg_ch.data[Q12_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_count_r <= RST_LAMP_COUNT;
      hue_step_r   <= RST_HUE_STEP;
      saturation_r <= RST_SATURATION;
      brightness_r <= RST_BRIGHTNESS;
    end else begin
      lamp_count_r <= lamp_count_nxt;
      hue_step_r   <= hue_step_nxt;
      saturation_r <= saturation_nxt;
      brightness_r <= brightness_nxt;
    end
  end

  // Clamp Q12 levels to one
  assign cfg.lamp_count = lamp_count_r;
  assign cfg.hue_step   = hue_step_r;
  assign cfg.saturation = (saturation_r > Q12_ONE) ? Q12_ONE : saturation_r;
  assign cfg.brightness = (brightness_r > Q12_ONE) ? Q12_ONE : brightness_r;

  hrl_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  hrl_seq #(
    .LAMPS (LAMPS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .head  (head),
    .pop   (pop),
    .adv   (adv),
    .issue (issue)
  );

  hrl_color #(
    .COLOR_BITS (COLOR_BITS)
  ) u_color (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .issue  (issue),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
